// ----- hw/rtl/min_or_index_delete_table_assert.svh -----
// assertion macros shared by the checker of the min/index delete table
`ifndef MIN_OR_INDEX_DELETE_TABLE_ASSERT_SVH
`define MIN_OR_INDEX_DELETE_TABLE_ASSERT_SVH

// same-cycle implication, clocked on aclk, off during reset
`define MITBL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on aclk, off during reset
`define MITBL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/mitbl_pkg.sv -----
// shared constants for the min/index delete table
package mitbl_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int VALUE_W   = 32;
    localparam int INDEX_W   = 6;
    localparam int FUNC_W    = 3;
    localparam int S_DATA_W  = 40;
    localparam int M_DATA_W  = 40;
    localparam int M_USER_W  = 1;

    localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_APPEND  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_DEL_IDX = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_DEL_MIN = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_EMIT    = 3'd4;

endpackage

// ----- hw/rtl/mitbl_ram.sv -----
// generic single-write, single-read ram with registered read data
module mitbl_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        // read data holds while rd_en is low
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- hw/rtl/min_or_index_delete_table.sv -----
// table of signed values with delete marks: top level and command sequencer
//
// Commands arrive on the s_ channel, one transaction each; s_tuser carries the
// command code (clear, append, delete by index, delete smallest, emit) and
// s_tdata the value and index. Only emit produces results on the m_ channel:
// one transaction per surviving entry in load order, tlast on the final one,
// or a single transaction with tuser 0 and tlast 1 when nothing survives.
// Clear, append, unused codes and a delete by an index below the count leave
// s_tready high. Delete smallest, or a delete by index at or past the count,
// keeps s_tready low while it scans: each live entry is read from the value
// ram, one per cycle, through the single read port into one shared signed
// comparator. Emit also keeps s_tready low while it scans; the same read port
// paces it, and with a free receiver survivors stream out at up to one
// per cycle. A stalled receiver holds the output register and, through it,
// pauses the emit scan; other commands are still taken while the last result
// of an emit waits. Reset clears the count, the delete marks and the output
// valid; the value ram needs no clearing since only entries below the count
// are ever read.
module min_or_index_delete_table #(
    parameter int DEPTH = mitbl_pkg::DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [mitbl_pkg::S_DATA_W-1:0] s_tdata,  // value[31:0], index[37:32], zeros
    input  logic [mitbl_pkg::FUNC_W-1:0]   s_tuser,  // func[2:0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mitbl_pkg::M_DATA_W-1:0] m_tdata,  // value_res[31:0], position[37:32], zeros
    output logic [mitbl_pkg::M_USER_W-1:0] m_tuser,  // valid_res[0]
    output logic                          m_tlast
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = mitbl_pkg::INDEX_W + 1;
    localparam int VW   = mitbl_pkg::VALUE_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MIN  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]                      state_reg, state_next;
    logic [CW-1:0]                   count_reg, count_next;
    logic [CW-1:0]                   ptr_reg, ptr_next;
    logic [DEPTH-1:0]                marks_reg, marks_next;
    logic                            rd_pend_reg, rd_pend_next;
    logic [AW-1:0]                   rpos_reg, rpos_next;
    logic                            found_reg, found_next;
    logic signed [VW-1:0]            best_val_reg, best_val_next;
    logic [AW-1:0]                   best_pos_reg, best_pos_next;
    logic                            hold_full_reg, hold_full_next;
    logic [VW-1:0]                   hold_val_reg, hold_val_next;
    logic [AW-1:0]                   hold_pos_reg, hold_pos_next;
    logic                            m_valid_reg, m_valid_next;
    logic [VW-1:0]                   m_val_reg, m_val_next;
    logic [AW-1:0]                   m_pos_reg, m_pos_next;
    logic                            m_vres_reg, m_vres_next;
    logic                            m_last_reg, m_last_next;

    logic [VW-1:0]                   s_value;
    logic [mitbl_pkg::INDEX_W-1:0]   s_index;
    logic                            idx_hit;
    logic                            out_free;
    logic                            take;
    logic                            ptr_live;

    logic                            ram_we;
    logic                            ram_re;
    logic [VW-1:0]                   ram_rdata;

    assign s_value  = s_tdata[VW-1:0];
    assign s_index  = s_tdata[VW +: mitbl_pkg::INDEX_W];
    assign s_tready = (state_reg == ST_IDLE);
    assign idx_hit  = {1'b0, s_index} < CMPW'(count_reg);
    assign out_free = !m_valid_reg || m_tready;
    assign ptr_live = (ptr_reg < count_reg);
    assign take     = rd_pend_reg && (!hold_full_reg || out_free);

    mitbl_ram #(
        .WIDTH (VW),
        .DEPTH (DEPTH),
        .ADDR_W(AW)
    ) u_ram (
        .clk    (aclk),
        .wr_en  (ram_we),
        .wr_addr(count_reg[AW-1:0]),
        .wr_data(s_value),
        .rd_en  (ram_re),
        .rd_addr(ptr_reg[AW-1:0]),
        .rd_data(ram_rdata)
    );

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        marks_next     = marks_reg;
        rd_pend_next   = rd_pend_reg;
        rpos_next      = rpos_reg;
        found_next     = found_reg;
        best_val_next  = best_val_reg;
        best_pos_next  = best_pos_reg;
        hold_full_next = hold_full_reg;
        hold_val_next  = hold_val_reg;
        hold_pos_next  = hold_pos_reg;
        m_valid_next   = m_valid_reg;
        m_val_next     = m_val_reg;
        m_pos_next     = m_pos_reg;
        m_vres_next    = m_vres_reg;
        m_last_next    = m_last_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                ptr_next       = '0;
                rd_pend_next   = 1'b0;
                found_next     = 1'b0;
                hold_full_next = 1'b0;
                if (s_tvalid) begin
                    case (s_tuser)
                        mitbl_pkg::FUNC_CLEAR: begin
                            count_next = '0;
                            marks_next = '0;
                        end
                        mitbl_pkg::FUNC_APPEND: begin
                            if (count_reg != CW'(DEPTH)) begin
                                ram_we                        = 1'b1;
                                marks_next[count_reg[AW-1:0]] = 1'b0;
                                count_next                    = count_reg + CW'(1);
                            end
                        end
                        mitbl_pkg::FUNC_DEL_IDX: begin
                            if (idx_hit) begin
                                marks_next[s_index[AW-1:0]] = 1'b1;
                            end else begin
                                state_next = ST_MIN;
                            end
                        end
                        mitbl_pkg::FUNC_DEL_MIN: begin
                            state_next = ST_MIN;
                        end
                        mitbl_pkg::FUNC_EMIT: begin
                            state_next = ST_EMIT;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_MIN: begin
                // strict less-than keeps the lower index on ties
                if (rd_pend_reg && (!found_reg || $signed(ram_rdata) < best_val_reg)) begin
                    found_next    = 1'b1;
                    best_val_next = $signed(ram_rdata);
                    best_pos_next = rpos_reg;
                end
                if (ptr_live) begin
                    ram_re       = !marks_reg[ptr_reg[AW-1:0]];
                    rd_pend_next = !marks_reg[ptr_reg[AW-1:0]];
                    rpos_next    = ptr_reg[AW-1:0];
                    ptr_next     = ptr_reg + CW'(1);
                end else begin
                    rd_pend_next = 1'b0;
                    if (!rd_pend_reg) begin
                        if (found_reg) begin
                            marks_next[best_pos_reg] = 1'b1;
                        end
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_EMIT: begin
                // one survivor is held back so tlast can go on the final one
                if (take) begin
                    if (hold_full_reg) begin
                        m_valid_next = 1'b1;
                        m_val_next   = hold_val_reg;
                        m_pos_next   = hold_pos_reg;
                        m_vres_next  = 1'b1;
                        m_last_next  = 1'b0;
                    end
                    hold_full_next = 1'b1;
                    hold_val_next  = ram_rdata;
                    hold_pos_next  = rpos_reg;
                    rd_pend_next   = 1'b0;
                end
                if (ptr_live) begin
                    if (marks_reg[ptr_reg[AW-1:0]]) begin
                        ptr_next = ptr_reg + CW'(1);
                    end else if (!rd_pend_reg || take) begin
                        ram_re       = 1'b1;
                        rd_pend_next = 1'b1;
                        rpos_next    = ptr_reg[AW-1:0];
                        ptr_next     = ptr_reg + CW'(1);
                    end
                end else if (!rd_pend_reg && out_free) begin
                    m_valid_next = 1'b1;
                    m_last_next  = 1'b1;
                    if (hold_full_reg) begin
                        m_val_next  = hold_val_reg;
                        m_pos_next  = hold_pos_reg;
                        m_vres_next = 1'b1;
                    end else begin
                        m_val_next  = '0;
                        m_pos_next  = '0;
                        m_vres_next = 1'b0;
                    end
                    hold_full_next = 1'b0;
                    state_next     = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            ptr_reg       <= '0;
            marks_reg     <= '0;
            rd_pend_reg   <= 1'b0;
            found_reg     <= 1'b0;
            hold_full_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            marks_reg     <= marks_next;
            rd_pend_reg   <= rd_pend_next;
            found_reg     <= found_next;
            hold_full_reg <= hold_full_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rpos_reg     <= rpos_next;
        best_val_reg <= best_val_next;
        best_pos_reg <= best_pos_next;
        hold_val_reg <= hold_val_next;
        hold_pos_reg <= hold_pos_next;
        m_val_reg    <= m_val_next;
        m_pos_reg    <= m_pos_next;
        m_vres_reg   <= m_vres_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(mitbl_pkg::M_DATA_W - VW - mitbl_pkg::INDEX_W){1'b0}},
                       mitbl_pkg::INDEX_W'(m_pos_reg), m_val_reg};
    assign m_tuser  = m_vres_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ----- hw/rtl/mitbl_chk.sv -----
// port-level checker for the min/index delete table, bound to the top level
`include "min_or_index_delete_table_assert.svh"

module mitbl_chk (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [mitbl_pkg::S_DATA_W-1:0] s_tdata,
    input logic [mitbl_pkg::FUNC_W-1:0]   s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [mitbl_pkg::M_DATA_W-1:0] m_tdata,
    input logic [mitbl_pkg::M_USER_W-1:0] m_tuser,
    input logic                          m_tlast
);

    // a stalled result keeps its contents
    `MITBL_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")

    // the no-survivor marker is empty and closes the run
    `MITBL_ASSERT_NOW(a_empty_marker, m_tvalid && (m_tuser == 1'b0), m_tlast && (m_tdata == '0), "bad empty emit result")

    // delete smallest and emit hold off the next command
    `MITBL_ASSERT_NEXT(a_scan_busy, s_tvalid && s_tready && ((s_tuser == mitbl_pkg::FUNC_DEL_MIN) || (s_tuser == mitbl_pkg::FUNC_EMIT)), !s_tready, "command taken during scan")

    // results are produced only while an emit scan holds the input
    `MITBL_ASSERT_NOW(a_out_from_scan, $rose(m_tvalid), $past(!s_tready), "result outside emit scan")

endmodule

bind min_or_index_delete_table mitbl_chk u_mitbl_chk (.*);
